### src/glu_pkg.sv
package glu_pkg;

  localparam int MAX_GRID_WIDTH  = 256;
  localparam int MAX_GRID_HEIGHT = 256;
  localparam int FRACTION_BITS   = 16;

  localparam int ADDR_W     = 16;
  localparam int TILE_DEPTH = 1 << ADDR_W;
  localparam int SAMPLE_W   = 16;
  localparam int GRID_W     = 9;
  localparam int SPAN_W     = 31;
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int DIFF_W     = 33;
  localparam int CFG_W      = 32;
  localparam int ELEV_W     = SAMPLE_W + 8;

  localparam int COL_W = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W = $clog2(MAX_GRID_HEIGHT);
  localparam int IDX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int QW     = IDX_W + FRACTION_BITS;
  localparam int PROD_W = SPAN_W + IDX_W;

  localparam int TOP_W     = SAMPLE_W + FRACTION_BITS;
  localparam int ACC_W     = SAMPLE_W + 2 * FRACTION_BITS;
  localparam int OUT_SHIFT = 2 * FRACTION_BITS - 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = SAMPLE_W'(1) << (SAMPLE_W - 1);
  localparam logic [ELEV_W-1:0]   ELEV_BIAS   = ELEV_W'(1) << (ELEV_W - 1);
  localparam logic [ACC_W-1:0]    ROUND_HALF  = ACC_W'(1) << (OUT_SHIFT - 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_NORTH_EDGE   = 3'd0,
    REG_WEST_EDGE    = 3'd1,
    REG_LAT_SPAN     = 3'd2,
    REG_LON_SPAN     = 3'd3,
    REG_GRID_WIDTH   = 3'd4,
    REG_GRID_HEIGHT  = 3'd5,
    REG_MISSING_CODE = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [ADDR_W-1:0]   index;
    logic [SAMPLE_W-1:0] value;
    logic [GRID_W-1:0]   w;
    logic [GRID_W-1:0]   h;
    logic                lat_zero;
    logic                lat_full;
    logic                lon_zero;
    logic                lon_full;
  } tag_t;

  typedef struct packed {
    logic                     valid;
    logic [SAMPLE_W-1:0]      tl;
    logic [SAMPLE_W-1:0]      tr;
    logic [SAMPLE_W-1:0]      bl;
    logic [SAMPLE_W-1:0]      br;
    logic [FRACTION_BITS-1:0] fx;
    logic [FRACTION_BITS-1:0] fy;
    logic                     lastcol;
    logic                     lastrow;
  } blend_in_t;

  function automatic logic [IDX_W-1:0] nm1_of(input logic [GRID_W-1:0] n);
    logic [GRID_W-1:0] d;
    d = n - GRID_W'(1);
    return d[IDX_W-1:0];
  endfunction

endpackage

### src/glu_tile_ram.sv
module glu_tile_ram (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [glu_pkg::ADDR_W-1:0]    addr0,
  input  logic [glu_pkg::SAMPLE_W-1:0]  wdata,
  input  logic [glu_pkg::ADDR_W-1:0]    addr1,
  output logic [glu_pkg::SAMPLE_W-1:0]  rdata0,
  output logic [glu_pkg::SAMPLE_W-1:0]  rdata1
);

  logic [glu_pkg::SAMPLE_W-1:0] mem [glu_pkg::TILE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr0] <= wdata;
      end
      rdata0 <= mem[addr0];
      rdata1 <= mem[addr1];
    end
  end

endmodule

### src/glu_pos_div.sv
module glu_pos_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  glu_pkg::tag_t                in_tag,
  input  logic [glu_pkg::PROD_W-1:0]   in_num_lat,
  input  logic [glu_pkg::PROD_W-1:0]   in_num_lon,
  input  logic [glu_pkg::SPAN_W-1:0]   span_lat,
  input  logic [glu_pkg::SPAN_W-1:0]   span_lon,
  output glu_pkg::tag_t                out_tag,
  output logic [glu_pkg::QW-1:0]       out_q_lat,
  output logic [glu_pkg::QW-1:0]       out_q_lon
);

  typedef struct packed {
    glu_pkg::tag_t                tag;
    logic [glu_pkg::SPAN_W-1:0]   r_lat;
    logic [glu_pkg::SPAN_W-1:0]   r_lon;
    logic [glu_pkg::QW-1:0]       n_lat;
    logic [glu_pkg::QW-1:0]       n_lon;
    logic [glu_pkg::QW-1:0]       q_lat;
    logic [glu_pkg::QW-1:0]       q_lon;
  } div_stage_t;

  div_stage_t st [glu_pkg::QW+1];
  div_stage_t st0_next;

  always_comb begin
    st0_next.tag   = in_tag;
    st0_next.r_lat = in_num_lat[glu_pkg::PROD_W-1:glu_pkg::IDX_W];
    st0_next.r_lon = in_num_lon[glu_pkg::PROD_W-1:glu_pkg::IDX_W];
    st0_next.n_lat = {in_num_lat[glu_pkg::IDX_W-1:0], {glu_pkg::FRACTION_BITS{1'b0}}};
    st0_next.n_lon = {in_num_lon[glu_pkg::IDX_W-1:0], {glu_pkg::FRACTION_BITS{1'b0}}};
    st0_next.q_lat = '0;
    st0_next.q_lon = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].tag.valid <= 1'b0;
    end else if (adv) begin
      st[0] <= st0_next;
    end
  end

  for (genvar k = 0; k < glu_pkg::QW; k++) begin : g_step
    logic [glu_pkg::SPAN_W:0] t_lat;
    logic [glu_pkg::SPAN_W:0] t_lon;
    logic                     ge_lat;
    logic                     ge_lon;
    logic [glu_pkg::SPAN_W:0] d_lat;
    logic [glu_pkg::SPAN_W:0] d_lon;
    div_stage_t               nxt;

    assign t_lat  = {st[k].r_lat, st[k].n_lat[glu_pkg::QW-1]};
    assign t_lon  = {st[k].r_lon, st[k].n_lon[glu_pkg::QW-1]};
    assign ge_lat = t_lat >= {1'b0, span_lat};
    assign ge_lon = t_lon >= {1'b0, span_lon};
    assign d_lat  = ge_lat ? (t_lat - {1'b0, span_lat}) : t_lat;
    assign d_lon  = ge_lon ? (t_lon - {1'b0, span_lon}) : t_lon;

    always_comb begin
      nxt.tag   = st[k].tag;
      nxt.r_lat = d_lat[glu_pkg::SPAN_W-1:0];
      nxt.r_lon = d_lon[glu_pkg::SPAN_W-1:0];
      nxt.n_lat = st[k].n_lat << 1;
      nxt.n_lon = st[k].n_lon << 1;
      nxt.q_lat = {st[k].q_lat[glu_pkg::QW-2:0], ge_lat};
      nxt.q_lon = {st[k].q_lon[glu_pkg::QW-2:0], ge_lon};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].tag.valid <= 1'b0;
      end else if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out_tag   = st[glu_pkg::QW].tag;
  assign out_q_lat = st[glu_pkg::QW].q_lat;
  assign out_q_lon = st[glu_pkg::QW].q_lon;

endmodule

### src/glu_blend.sv
module glu_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  glu_pkg::blend_in_t            in,
  input  logic [glu_pkg::SAMPLE_W-1:0]  missing_code,
  output logic                          out_valid,
  output logic [glu_pkg::ELEV_W-1:0]    elevation,
  output logic                          is_missing
);

  localparam int MT_W = glu_pkg::TOP_W + 2;
  localparam int MA_W = glu_pkg::TOP_W + glu_pkg::FRACTION_BITS + 2;

  typedef struct packed {
    logic                              valid;
    logic                              miss;
    logic [glu_pkg::TOP_W-1:0]         top;
    logic [glu_pkg::TOP_W-1:0]         bot;
    logic [glu_pkg::FRACTION_BITS-1:0] fy;
  } mix_stage_t;

  typedef struct packed {
    logic                      valid;
    logic                      miss;
    logic [glu_pkg::ACC_W-1:0] acc;
  } acc_stage_t;

  mix_stage_t d_q, d_next;
  acc_stage_t e_q, e_next;

  logic [glu_pkg::SAMPLE_W-1:0] trx, blx, brx;
  logic [glu_pkg::SAMPLE_W-1:0] utl, utr, ubl, ubr;
  logic                         dup;
  logic signed [glu_pkg::SAMPLE_W:0] dtop, dbot;
  logic signed [glu_pkg::FRACTION_BITS:0] fxs, fys;
  logic signed [MT_W-1:0] mt, mb, st_top, st_bot;
  logic signed [glu_pkg::TOP_W:0] dacc;
  logic signed [MA_W-1:0] ma, sacc;
  logic [glu_pkg::ACC_W-1:0] rsum;
  logic [glu_pkg::ELEV_W-1:0] rnd;

  always_comb begin
    dup = in.lastcol || in.lastrow;
    trx = in.lastcol ? in.tl : in.tr;
    blx = dup ? in.tl : in.bl;
    brx = dup ? trx : in.br;
    utl = in.tl ^ glu_pkg::SAMPLE_BIAS;
    utr = trx ^ glu_pkg::SAMPLE_BIAS;
    ubl = blx ^ glu_pkg::SAMPLE_BIAS;
    ubr = brx ^ glu_pkg::SAMPLE_BIAS;
    dtop = $signed({1'b0, utr}) - $signed({1'b0, utl});
    dbot = $signed({1'b0, ubr}) - $signed({1'b0, ubl});
    fxs  = $signed({1'b0, in.fx});
    mt = dtop * fxs;
    mb = dbot * fxs;
    st_top = $signed({2'b00, utl, {glu_pkg::FRACTION_BITS{1'b0}}}) + mt;
    st_bot = $signed({2'b00, ubl, {glu_pkg::FRACTION_BITS{1'b0}}}) + mb;
    d_next.valid = in.valid;
    d_next.miss  = (in.tl == missing_code) || (trx == missing_code) ||
                   (!dup && ((in.bl == missing_code) || (in.br == missing_code)));
    d_next.top = st_top[glu_pkg::TOP_W-1:0];
    d_next.bot = st_bot[glu_pkg::TOP_W-1:0];
    d_next.fy  = in.fy;
  end

  always_comb begin
    dacc = $signed({1'b0, d_q.bot}) - $signed({1'b0, d_q.top});
    fys  = $signed({1'b0, d_q.fy});
    ma   = dacc * fys;
    sacc = $signed({2'b00, d_q.top, {glu_pkg::FRACTION_BITS{1'b0}}}) + ma;
    e_next.valid = d_q.valid;
    e_next.miss  = d_q.miss;
    e_next.acc   = sacc[glu_pkg::ACC_W-1:0];
  end

  assign rsum = e_q.acc + glu_pkg::ROUND_HALF;
  assign rnd  = glu_pkg::ELEV_W'(rsum >> glu_pkg::OUT_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_q.valid <= 1'b0;
      e_q.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      d_q       <= d_next;
      e_q       <= e_next;
      out_valid <= e_q.valid;
      is_missing <= e_q.miss;
      if (e_q.miss) begin
        elevation <= {missing_code, {(glu_pkg::ELEV_W - glu_pkg::SAMPLE_W){1'b0}}};
      end else begin
        elevation <= rnd - glu_pkg::ELEV_BIAS;
      end
    end
  end

endmodule

### src/grid_bilinear_elevation_lookup_unit.sv
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tuser opcode; tdata index, value, lat, lon
// m_axis   out  m_axis_tvalid/m_axis_tready    tuser is_missing; tdata elevation
// cfg      in   cfg_we                         cfg_index, cfg_data
//
// The item behind a write is taken without hold-off; a query reads its four
// neighbour samples through both tile memory ports, top pair first, then
// bottom pair, so the item behind it is held off. The position divider is
// pipelined in 24 steps. rst clears valid bits and resets config registers;
// the tile is undefined until written. A stalled m_axis holds the whole pipeline.
module grid_bilinear_elevation_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // sample_index, sample_value, query_lat, query_lon, pad
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // elevation
  output logic        m_axis_tuser,  // is_missing
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    glu_pkg::tag_t              tag;
    logic [glu_pkg::SPAN_W-1:0] d_lat;
    logic [glu_pkg::SPAN_W-1:0] d_lon;
  } diff_stage_t;

  typedef struct packed {
    glu_pkg::tag_t              tag;
    logic [glu_pkg::PROD_W-1:0] p_lat;
    logic [glu_pkg::PROD_W-1:0] p_lon;
  } prod_stage_t;

  typedef struct packed {
    glu_pkg::tag_t                     tag;
    logic [glu_pkg::ADDR_W-1:0]        k;
    logic [glu_pkg::ADDR_W-1:0]        kw;
    logic [glu_pkg::FRACTION_BITS-1:0] fx;
    logic [glu_pkg::FRACTION_BITS-1:0] fy;
    logic                              lastcol;
    logic                              lastrow;
  } addr_stage_t;

  typedef struct packed {
    addr_stage_t                  a;
    logic [glu_pkg::SAMPLE_W-1:0] tl;
    logic [glu_pkg::SAMPLE_W-1:0] tr;
  } read_stage_t;

  logic signed [glu_pkg::LAT_W-1:0]  north_edge;
  logic signed [glu_pkg::LON_W-1:0]  west_edge;
  logic [glu_pkg::SPAN_W-1:0]        lat_span;
  logic [glu_pkg::SPAN_W-1:0]        lon_span;
  logic [glu_pkg::GRID_W-1:0]        grid_width;
  logic [glu_pkg::GRID_W-1:0]        grid_height;
  logic [glu_pkg::SAMPLE_W-1:0]      missing_code;

  logic adv;
  logic [glu_pkg::SPAN_W-1:0] span_lat_eff, span_lon_eff;
  logic [glu_pkg::GRID_W-1:0] w_c, h_c;
  logic signed [glu_pkg::DIFF_W-1:0] dlat, dlon;
  logic [glu_pkg::LAT_W-1:0] q_lat_in;
  logic [glu_pkg::LON_W-1:0] q_lon_in;

  diff_stage_t s0, s0_next;
  prod_stage_t s1, s1_next;
  addr_stage_t a_q, a_next, b_q;
  read_stage_t c_q;

  glu_pkg::tag_t dv_tag;
  logic [glu_pkg::QW-1:0] dv_q_lat, dv_q_lon, py, px;
  logic [glu_pkg::IDX_W-1:0] j_idx, i_idx, nm1_w, nm1_h;

  logic b_query, a_write;
  logic [glu_pkg::ADDR_W-1:0] addr0, addr1;
  logic [glu_pkg::SAMPLE_W-1:0] rdata0, rdata1;
  glu_pkg::blend_in_t bin;
  logic out_valid;
  logic [glu_pkg::ELEV_W-1:0] elevation;
  logic is_missing;

  always_ff @(posedge clk) begin
    if (rst) begin
      north_edge   <= '0;
      west_edge    <= '0;
      lat_span     <= glu_pkg::SPAN_W'(1);
      lon_span     <= glu_pkg::SPAN_W'(1);
      grid_width   <= glu_pkg::GRID_W'(glu_pkg::MAX_GRID_WIDTH);
      grid_height  <= glu_pkg::GRID_W'(glu_pkg::MAX_GRID_HEIGHT);
      missing_code <= glu_pkg::SAMPLE_BIAS;
    end else if (cfg_we) begin
      case (cfg_index)
        glu_pkg::REG_NORTH_EDGE:   north_edge   <= cfg_data[glu_pkg::LAT_W-1:0];
        glu_pkg::REG_WEST_EDGE:    west_edge    <= cfg_data[glu_pkg::LON_W-1:0];
        glu_pkg::REG_LAT_SPAN:     lat_span     <= cfg_data[glu_pkg::SPAN_W-1:0];
        glu_pkg::REG_LON_SPAN:     lon_span     <= cfg_data[glu_pkg::SPAN_W-1:0];
        glu_pkg::REG_GRID_WIDTH:   grid_width   <= cfg_data[glu_pkg::GRID_W-1:0];
        glu_pkg::REG_GRID_HEIGHT:  grid_height  <= cfg_data[glu_pkg::GRID_W-1:0];
        glu_pkg::REG_MISSING_CODE: missing_code <= cfg_data[glu_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv = !out_valid || m_axis_tready;
  // hold off the item behind a query so the memory ports stay free
  assign s_axis_tready = adv && !(s0.tag.valid && s0.tag.op == glu_pkg::OP_QUERY);

  assign span_lat_eff = (lat_span == '0) ? glu_pkg::SPAN_W'(1) : lat_span;
  assign span_lon_eff = (lon_span == '0) ? glu_pkg::SPAN_W'(1) : lon_span;

  always_comb begin
    w_c = grid_width;
    if (grid_width < glu_pkg::GRID_W'(2)) begin
      w_c = glu_pkg::GRID_W'(2);
    end else if (grid_width > glu_pkg::GRID_W'(glu_pkg::MAX_GRID_WIDTH)) begin
      w_c = glu_pkg::GRID_W'(glu_pkg::MAX_GRID_WIDTH);
    end
    h_c = grid_height;
    if (grid_height < glu_pkg::GRID_W'(2)) begin
      h_c = glu_pkg::GRID_W'(2);
    end else if (grid_height > glu_pkg::GRID_W'(glu_pkg::MAX_GRID_HEIGHT)) begin
      h_c = glu_pkg::GRID_W'(glu_pkg::MAX_GRID_HEIGHT);
    end
  end

  always_comb begin
    q_lat_in = s_axis_tdata[62:32];
    q_lon_in = s_axis_tdata[94:63];
    dlat = $signed({{(glu_pkg::DIFF_W - glu_pkg::LAT_W){north_edge[glu_pkg::LAT_W-1]}},
                    north_edge})
         - $signed({{(glu_pkg::DIFF_W - glu_pkg::LAT_W){q_lat_in[glu_pkg::LAT_W-1]}},
                    q_lat_in});
    dlon = $signed({{(glu_pkg::DIFF_W - glu_pkg::LON_W){q_lon_in[glu_pkg::LON_W-1]}},
                    q_lon_in})
         - $signed({{(glu_pkg::DIFF_W - glu_pkg::LON_W){west_edge[glu_pkg::LON_W-1]}},
                    west_edge});
    s0_next.tag.valid    = s_axis_tvalid && s_axis_tready;
    s0_next.tag.op       = glu_pkg::op_t'(s_axis_tuser);
    s0_next.tag.index    = s_axis_tdata[15:0];
    s0_next.tag.value    = s_axis_tdata[31:16];
    s0_next.tag.w        = w_c;
    s0_next.tag.h        = h_c;
    s0_next.tag.lat_zero = dlat <= 0;
    s0_next.tag.lat_full = dlat >= $signed({2'b00, span_lat_eff});
    s0_next.tag.lon_zero = dlon <= 0;
    s0_next.tag.lon_full = dlon >= $signed({2'b00, span_lon_eff});
    s0_next.d_lat = (s0_next.tag.lat_zero || s0_next.tag.lat_full) ? '0 :
                    dlat[glu_pkg::SPAN_W-1:0];
    s0_next.d_lon = (s0_next.tag.lon_zero || s0_next.tag.lon_full) ? '0 :
                    dlon[glu_pkg::SPAN_W-1:0];
  end

  always_comb begin
    s1_next.tag   = s0.tag;
    s1_next.p_lat = glu_pkg::PROD_W'(s0.d_lat) *
                    glu_pkg::PROD_W'(glu_pkg::nm1_of(s0.tag.h));
    s1_next.p_lon = glu_pkg::PROD_W'(s0.d_lon) *
                    glu_pkg::PROD_W'(glu_pkg::nm1_of(s0.tag.w));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.tag.valid <= 1'b0;
      s1.tag.valid <= 1'b0;
    end else if (adv) begin
      s0 <= s0_next;
      s1 <= s1_next;
    end
  end

  glu_pos_div u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_tag     (s1.tag),
    .in_num_lat (s1.p_lat),
    .in_num_lon (s1.p_lon),
    .span_lat   (span_lat_eff),
    .span_lon   (span_lon_eff),
    .out_tag    (dv_tag),
    .out_q_lat  (dv_q_lat),
    .out_q_lon  (dv_q_lon)
  );

  always_comb begin
    nm1_w = glu_pkg::nm1_of(dv_tag.w);
    nm1_h = glu_pkg::nm1_of(dv_tag.h);
    if (dv_tag.lat_zero) begin
      py = '0;
    end else if (dv_tag.lat_full) begin
      py = {nm1_h, {glu_pkg::FRACTION_BITS{1'b0}}};
    end else begin
      py = dv_q_lat;
    end
    if (dv_tag.lon_zero) begin
      px = '0;
    end else if (dv_tag.lon_full) begin
      px = {nm1_w, {glu_pkg::FRACTION_BITS{1'b0}}};
    end else begin
      px = dv_q_lon;
    end
    j_idx = py[glu_pkg::QW-1:glu_pkg::FRACTION_BITS];
    i_idx = px[glu_pkg::QW-1:glu_pkg::FRACTION_BITS];
    a_next.tag = dv_tag;
    a_next.k   = glu_pkg::ADDR_W'(glu_pkg::ADDR_W'(j_idx) * glu_pkg::ADDR_W'(dv_tag.w))
               + glu_pkg::ADDR_W'(i_idx);
    a_next.kw  = a_next.k + glu_pkg::ADDR_W'(dv_tag.w);
    a_next.fx  = px[glu_pkg::FRACTION_BITS-1:0];
    a_next.fy  = py[glu_pkg::FRACTION_BITS-1:0];
    a_next.lastcol = i_idx == nm1_w;
    a_next.lastrow = j_idx == nm1_h;
  end

  assign b_query = b_q.tag.valid && b_q.tag.op == glu_pkg::OP_QUERY;
  assign a_write = a_q.tag.valid && a_q.tag.op == glu_pkg::OP_WRITE;

  always_comb begin
    if (b_query) begin
      addr0 = b_q.kw;
      addr1 = b_q.kw + glu_pkg::ADDR_W'(1);
    end else if (a_write) begin
      addr0 = a_q.tag.index;
      addr1 = a_q.k + glu_pkg::ADDR_W'(1);
    end else begin
      addr0 = a_q.k;
      addr1 = a_q.k + glu_pkg::ADDR_W'(1);
    end
  end

  glu_tile_ram u_ram (
    .clk    (clk),
    .en     (adv),
    .we     (a_write),
    .addr0  (addr0),
    .wdata  (a_q.tag.value),
    .addr1  (addr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_q.tag.valid   <= 1'b0;
      b_q.tag.valid   <= 1'b0;
      c_q.a.tag.valid <= 1'b0;
    end else if (adv) begin
      a_q   <= a_next;
      b_q   <= a_q;
      c_q.a <= b_q;
      c_q.tl <= rdata0;
      c_q.tr <= rdata1;
    end
  end

  always_comb begin
    bin.valid   = c_q.a.tag.valid && c_q.a.tag.op == glu_pkg::OP_QUERY;
    bin.tl      = c_q.tl;
    bin.tr      = c_q.tr;
    bin.bl      = rdata0;
    bin.br      = rdata1;
    bin.fx      = c_q.a.fx;
    bin.fy      = c_q.a.fy;
    bin.lastcol = c_q.a.lastcol;
    bin.lastrow = c_q.a.lastrow;
  end

  glu_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in           (bin),
    .missing_code (missing_code),
    .out_valid    (out_valid),
    .elevation    (elevation),
    .is_missing   (is_missing)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = elevation;
  assign m_axis_tuser  = is_missing;

  a_query_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == glu_pkg::OP_QUERY |=> !s_axis_tready)
    else $error("item accepted right behind a query");

  a_port_free: assert property (@(posedge clk) disable iff (rst)
    !(a_write && b_query))
    else $error("tile write collides with neighbour read");

  a_miss_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("missing result not scaled code");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(c_q.a.tag.valid) && $stable(dv_tag.valid))
    else $error("pipeline moved while stalled");

endmodule

### tb/sv/grid_bilinear_elevation_lookup_unit_tb.sv
`timescale 1ns / 1ps

module grid_bilinear_elevation_lookup_unit_tb;
  import glu_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [23:0] elev;
    logic        miss;
  } elev_t;

  typedef struct {
    op_t          op;
    logic [15:0]  idx;
    logic [15:0]  val;
    logic [30:0]  lat;
    logic [31:0]  lon;
    bit           typed;
    logic [23:0]  elev;
    logic         miss;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  grid_bilinear_elevation_lookup_unit u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [30:0] north_r;
  logic signed [31:0] west_r;
  logic [30:0]        lat_span_r, lon_span_r;
  logic [8:0]         width_r, height_r;
  logic [15:0]        missing_r;
  logic [15:0]        tile [TILE_DEPTH];
  bit                 written [TILE_DEPTH];

  elev_t pending_elev[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    no_gaps = 1'b0;
  int    sent = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned scale_pos(input longint d, input longint unsigned span,
                                                input longint unsigned nm1);
    if (span == 0) span = 1;
    if (d <= 0) return 0;
    if (longint'(d) >= longint'(span)) return nm1 << FRACTION_BITS;
    return ((longint'(d) * nm1) << FRACTION_BITS) / span;
  endfunction

  // addresses read by a query; count says how many are used
  function automatic void locate(input logic [30:0] lat, input logic [31:0] lon,
                                 output logic [15:0] addr [4], output int count,
                                 output longint unsigned fx, output longint unsigned fy);
    longint unsigned w, h, px, py, i, j, k;
    w = (width_r < 2) ? 2 : (width_r > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : width_r;
    h = (height_r < 2) ? 2 : (height_r > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : height_r;
    py = scale_pos(longint'(north_r) - longint'($signed(lat)), lat_span_r, h - 1);
    px = scale_pos(longint'($signed(lon)) - longint'(west_r), lon_span_r, w - 1);
    j = py >> FRACTION_BITS;
    i = px >> FRACTION_BITS;
    fy = py & 16'hFFFF;
    fx = px & 16'hFFFF;
    k = j * w + i;
    addr[0] = 16'(k);
    addr[1] = 16'(k + 1);
    addr[2] = 16'(k + w);
    addr[3] = 16'(k + w + 1);
    if (i >= w - 1) count = 1;
    else if (j >= h - 1) count = 2;
    else count = 4;
  endfunction

  function automatic elev_t lookup_elevation(input logic [30:0] lat, input logic [31:0] lon);
    logic [15:0] addr [4];
    logic [15:0] s [4];
    int cnt;
    longint unsigned fx, fy, top, bot, acc, r;
    elev_t e;
    locate(lat, lon, addr, cnt, fx, fy);
    s[0] = tile[addr[0]];
    s[1] = (cnt > 1) ? tile[addr[1]] : s[0];
    s[2] = (cnt == 4) ? tile[addr[2]] : s[0];
    s[3] = (cnt == 4) ? tile[addr[3]] : s[1];
    if (s[0] == missing_r || s[1] == missing_r || s[2] == missing_r || s[3] == missing_r) begin
      e.elev = {missing_r, 8'h00};
      e.miss = 1'b1;
      return e;
    end
    top = longint'(s[0] ^ 16'h8000) * (65536 - fx) + longint'(s[1] ^ 16'h8000) * fx;
    bot = longint'(s[2] ^ 16'h8000) * (65536 - fx) + longint'(s[3] ^ 16'h8000) * fx;
    acc = top * (65536 - fy) + bot * fy;
    r = (acc + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    e.elev = 24'(r - 32768 * 256);
    e.miss = 1'b0;
    return e;
  endfunction

  task automatic send_item(input row_t it);
    int g;
    elev_t e;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {1'b0, it.lon, it.lat, it.val, it.idx};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    if (it.op == OP_WRITE) begin
      tile[it.idx] = it.val;
      written[it.idx] = 1'b1;
    end else begin
      if (it.typed) begin
        e.elev = it.elev;
        e.miss = it.miss;
      end else begin
        e = lookup_elevation(it.lat, it.lon);
      end
      pending_elev.insert(pending_elev.size(), e);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_elev.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] v [7]);
    for (int r = 0; r < 7; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data <= v[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    north_r = v[REG_NORTH_EDGE][30:0];
    west_r = v[REG_WEST_EDGE];
    lat_span_r = v[REG_LAT_SPAN][30:0];
    lon_span_r = v[REG_LON_SPAN][30:0];
    width_r = v[REG_GRID_WIDTH][8:0];
    height_r = v[REG_GRID_HEIGHT][8:0];
    missing_r = v[REG_MISSING_CODE][15:0];
  endtask

  function automatic logic [30:0] pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 31'd1;
    if (r == 1) return 31'd1800000000;
    if (r == 2) return 31'h7FFFFFFF;
    if (r < 6) return 31'($urandom_range(2, 5000));
    return 31'($urandom_range(1, 1800000000));
  endfunction

  function automatic logic [8:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 9'($urandom_range(0, 2));
    if (r == 1) return 9'($urandom_range(256, 511));
    return 9'($urandom_range(2, 256));
  endfunction

  task automatic random_query();
    row_t q;
    logic [15:0] addr [4];
    int cnt;
    longint unsigned fx, fy;
    longint dl, dn;
    row_t wr;
    dl = (lat_span_r == 0) ? 1 : lat_span_r;
    dn = (lon_span_r == 0) ? 1 : lon_span_r;
    q.op = OP_QUERY;
    q.idx = 16'($urandom);
    q.val = 16'($urandom);
    q.typed = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      q.lat = 31'($urandom);
      q.lon = $urandom;
    end else begin
      q.lat = 31'(longint'(north_r) - longint'($urandom_range(0, 32'(dl))) +
                  (($urandom_range(0, 15) == 0) ? 2 : 0));
      q.lon = 32'(longint'(west_r) + longint'($urandom_range(0, 32'(dn))) -
                  (($urandom_range(0, 15) == 0) ? 2 : 0));
    end
    locate(q.lat, q.lon, addr, cnt, fx, fy);
    for (int n = 0; n < cnt; n++) begin
      if (!written[addr[n]] || $urandom_range(0, 39) == 0) begin
        wr = q;
        wr.op = OP_WRITE;
        wr.idx = addr[n];
        wr.val = ($urandom_range(0, 29) == 0) ? missing_r : 16'($urandom);
        wr.lat = 31'($urandom);
        wr.lon = $urandom;
        send_item(wr);
      end
    end
    send_item(q);
  endtask

  always @(posedge clk) begin
    elev_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_elev.size() == 0) begin
        report($sformatf("unexpected result %h/%b", m_axis_tdata, m_axis_tuser));
      end else begin
        e = pending_elev.pop_front();
        if (m_axis_tdata !== e.elev)
          report($sformatf("elevation %h, want %h", m_axis_tdata, e.elev));
        if (m_axis_tuser !== e.miss)
          report($sformatf("is_missing %b, want %b", m_axis_tuser, e.miss));
      end
    end
  end

  int ready_left = 0;
  always @(posedge clk) begin
    if (ready_left == 0) begin
      if (no_gaps || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        ready_left <= $urandom_range(1, 20);
      end else begin
        m_axis_tready <= 1'b0;
        ready_left <= gap_len() + 1;
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t directed [] = '{
    '{OP_WRITE, 16'd0,     16'd100,    31'h40000000, 32'h80000000, 0, '0, 0},
    '{OP_WRITE, 16'd1,     16'd200,    31'h3FFFFFFF, 32'h7FFFFFFF, 0, '0, 0},
    '{OP_WRITE, 16'd256,   16'd300,    '0, '0, 0, '0, 0},
    '{OP_WRITE, 16'd257,   16'd400,    '0, '0, 0, '0, 0},
    '{OP_QUERY, 16'hFFFF,  16'hFFFF,   31'd0, 32'd0, 1, 24'd25600, 0},
    '{OP_QUERY, '0, '0, 31'd900000000, -32'sd1800000000, 1, 24'd25600, 0},
    '{OP_WRITE, 16'd65280, 16'h7FFF,   '0, '0, 0, '0, 0},
    '{OP_WRITE, 16'd65281, 16'h8001,   '0, '0, 0, '0, 0},
    '{OP_QUERY, '0, '0, -31'sd5, 32'd0, 1, 24'h7FFF00, 0},
    '{OP_WRITE, 16'd65535, 16'h8001,   '0, '0, 0, '0, 0},
    '{OP_QUERY, '0, '0, -31'sd900000000, 32'd1800000000, 1, 24'h800100, 0},
    '{OP_WRITE, 16'd1,     16'h8000,   '0, '0, 0, '0, 0},
    '{OP_QUERY, '0, '0, 31'd0, 32'd0, 1, 24'h800000, 1},
    '{OP_QUERY, '0, '0, -31'sd3, 32'd0, 1, 24'h7FFF00, 0},
    '{OP_WRITE, 16'd1,     16'd200,    '0, '0, 0, '0, 0},
    '{OP_QUERY, '0, '0, 31'd0, 32'd0, 0, '0, 0}
  };

  initial begin
    logic [31:0] v [7];
    int target;
    north_r = 0;
    west_r = 0;
    lat_span_r = 1;
    lon_span_r = 1;
    width_r = 256;
    height_r = 256;
    missing_r = 16'h8000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[n]) send_item(directed[n]);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: v = '{32'd900000000, -32'sd1800000000, 32'd1800000000, 32'd1800000000,
                 32'd256, 32'd256, 32'h7FFF};
        1: v = '{-32'sd900000000, 32'd1800000000, 32'd1, 32'd1, 32'd2, 32'd2, 32'hFFFF8000};
        2: v = '{32'd1000, -32'sd1000, 32'd0, 32'd0, 32'd0, 32'd511, 32'd0};
        3: v = '{32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'd1, 32'd300, 32'd7};
        default: v = '{$urandom, $urandom, 32'(pick_span()), 32'(pick_span()),
                       32'(pick_size()), 32'(pick_size()), $urandom};
      endcase
      write_regs(v);
      no_gaps = (ph == 3);
      target = sent + 200;
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0)
          send_item('{OP_WRITE, 16'($urandom), 16'($urandom), 31'($urandom), $urandom,
                      0, '0, 0});
        else
          random_query();
        if (sent - target == -100) drain();
      end
      drain();
    end
    if (pending_elev.size() != 0) report("results left over");
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
